// File: rtl/vsrf_pkg.sv
// Shared types and constants for the variable-step relaxation filter.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package vsrf_pkg;

  localparam int NUM_COMP   = 5;
  localparam int COMP_IDX_W = $clog2(NUM_COMP);
  localparam int STAMP_W    = 32;
  localparam int TICKS_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELAX_ENABLE = 1'b0,
    CFG_RELAX_TICKS  = 1'b1
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  capture;   // latch the incoming item
    logic                  check;     // latch the reload flag
    logic                  load_raw;  // copy raw vector into the state
    logic                  set_stamp; // last stamp <= captured stamp
    logic                  init_div;  // seed the divider
    logic                  div_step;  // one quotient bit
    logic                  sub;       // difference and magnitude of one component
    logic                  mul_lo;    // low half partial product
    logic                  mul_hi;    // high half partial product, accumulate
    logic                  write;     // round, apply and clamp one component
    logic                  load_out;  // move state into the output register
    logic [COMP_IDX_W-1:0] comp;      // component in work
  } vsrf_cmd_t;

  // Status from the datapath, valid while the item is checked.
  typedef struct packed {
    logic reload; // disabled, empty or stamp went back
    logic same;   // stamp equals the last one
    logic full;   // elapsed reaches the time constant
  } vsrf_status_t;

endpackage

`default_nettype wire

// File: rtl/vsrf_ctrl.sv
// Sequencing controller of the variable-step relaxation filter.
// Depends on vsrf_pkg; drives the vsrf_datapath command struct.
`default_nettype none

module vsrf_ctrl import vsrf_pkg::*; #(
  parameter int FACTOR_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire vsrf_status_t status_i,
  output vsrf_cmd_t         cmd_o
);

  localparam int CNT_W = $clog2(FACTOR_BITS);
  localparam logic [CNT_W-1:0]      CNT_LAST  = CNT_W'(FACTOR_BITS - 1);
  localparam logic [COMP_IDX_W-1:0] COMP_LAST = COMP_IDX_W'(NUM_COMP - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_SUB    = 8'b0000_1000,
    S_MUL_LO = 8'b0001_0000,
    S_MUL_HI = 8'b0010_0000,
    S_WRITE  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [COMP_IDX_W-1:0] comp_q, comp_d;
  logic                  out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    comp_d      = comp_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.comp  = comp_q;
    in_ready_o  = 1'b0;

    // drop the result once the receiver takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        priority if (status_i.reload) begin
          cmd_o.load_raw  = 1'b1;
          cmd_o.set_stamp = 1'b1;
          state_d         = S_DONE;
        end else if (status_i.same) begin
          state_d = S_DONE;
        end else if (status_i.full) begin
          cmd_o.load_raw  = 1'b1;
          cmd_o.set_stamp = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.set_stamp = 1'b1;
          cmd_o.init_div  = 1'b1;
          cnt_d           = '0;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          comp_d  = '0;
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        if (comp_q == COMP_LAST) begin
          state_d = S_DONE;
        end else begin
          comp_d  = comp_q + COMP_IDX_W'(1);
          state_d = S_SUB;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/vsrf_datapath.sv
// Datapath of the variable-step relaxation filter: state, divider, shared multiplier.
// Depends on vsrf_pkg; steered by vsrf_ctrl.
`default_nettype none

module vsrf_datapath import vsrf_pkg::*; #(
  parameter int MOMENT_WIDTH = 32,
  parameter int FACTOR_BITS  = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire vsrf_cmd_t                      cmd_i,
  output vsrf_status_t                        status_o,
  input  wire logic                           relax_enable_i,
  input  wire logic [TICKS_W-1:0]             relax_ticks_i,
  input  wire logic [STAMP_W-1:0]             stamp_i,
  input  wire logic signed [MOMENT_WIDTH-1:0] raw_i [NUM_COMP],
  output logic signed [MOMENT_WIDTH-1:0]      filt_o [NUM_COMP],
  output logic                                reloaded_o
);

  localparam int MW    = MOMENT_WIDTH;
  localparam int FB    = FACTOR_BITS;
  localparam int MAG_W = MW + 1;
  localparam int LO_W  = (MAG_W + 1) / 2;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int ACC_W = MAG_W + FB;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FB - 1);
  localparam logic signed [MW-1:0] MOM_MAX = {1'b0, {(MW-1){1'b1}}};
  localparam logic signed [MW-1:0] MOM_MIN = {1'b1, {(MW-1){1'b0}}};

  logic [STAMP_W-1:0]   stamp_q;
  logic signed [MW-1:0] raw_q  [NUM_COMP];
  logic signed [MW-1:0] filt_q [NUM_COMP];
  logic [STAMP_W-1:0]   last_q;
  logic                 have_q;
  logic                 reloaded_q;
  logic [TICKS_W-1:0]   rem_q;
  logic [FB-1:0]        factor_q;
  logic [MAG_W-1:0]     mag_q;
  logic                 neg_q;
  logic [ACC_W-1:0]     acc_q;
  logic signed [MW-1:0] out_filt_q [NUM_COMP];
  logic                 out_rel_q;

  logic [STAMP_W-1:0]   elapsed;
  logic [TICKS_W:0]     rem_shift;
  logic                 qbit;
  logic signed [MW-1:0] cur_sel, raw_sel;
  logic [MAG_W-1:0]     diff;
  logic [LO_W+FB-1:0]   prod_lo;
  logic [HI_W+FB-1:0]   prod_hi;
  logic [ACC_W-1:0]     rnd;
  logic [MAG_W-1:0]     step;
  logic [MW+1:0]        cur_ext, step_ext, sum;
  logic signed [MW-1:0] next_val;

  assign elapsed         = stamp_q - last_q;
  assign status_o.reload = !relax_enable_i || !have_q || (stamp_q < last_q);
  assign status_o.same   = (stamp_q == last_q);
  assign status_o.full   = (elapsed >= relax_ticks_i);

  // restoring divider: remainder stays below the time constant
  assign rem_shift = {rem_q, 1'b0};
  assign qbit      = (rem_shift >= {1'b0, relax_ticks_i});

  assign cur_sel = filt_q[cmd_i.comp];
  assign raw_sel = raw_q[cmd_i.comp];
  assign diff    = {raw_sel[MW-1], raw_sel} - {cur_sel[MW-1], cur_sel};

  assign prod_lo = mag_q[LO_W-1:0] * factor_q;
  assign prod_hi = mag_q[MAG_W-1:LO_W] * factor_q;

  // round half away from zero on the magnitude, then apply the sign
  assign rnd      = acc_q + HALF;
  assign step     = rnd[ACC_W-1:FB];
  assign cur_ext  = {{2{cur_sel[MW-1]}}, cur_sel};
  assign step_ext = {1'b0, step};
  assign sum      = neg_q ? (cur_ext - step_ext) : (cur_ext + step_ext);

  always_comb begin
    if (sum[MW+1:MW-1] == '0 || sum[MW+1:MW-1] == '1) begin
      next_val = sum[MW-1:0];
    end else if (sum[MW+1]) begin
      next_val = MOM_MIN;
    end else begin
      next_val = MOM_MAX;
    end
  end

  // filter state and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      have_q     <= 1'b0;
      reloaded_q <= 1'b0;
      for (int i = 0; i < NUM_COMP; i++) begin
        filt_q[i] <= '0;
      end
    end else begin
      if (cmd_i.check) begin
        reloaded_q <= status_o.reload;
      end
      if (cmd_i.set_stamp) begin
        last_q <= stamp_q;
      end
      if (cmd_i.load_raw) begin
        have_q <= 1'b1;
        for (int i = 0; i < NUM_COMP; i++) begin
          filt_q[i] <= raw_q[i];
        end
      end
      if (cmd_i.write) begin
        filt_q[cmd_i.comp] <= next_val;
      end
    end
  end

  // working registers and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      stamp_q <= stamp_i;
      for (int i = 0; i < NUM_COMP; i++) begin
        raw_q[i] <= raw_i[i];
      end
    end
    if (cmd_i.init_div) begin
      rem_q    <= elapsed;
      factor_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q    <= qbit ? TICKS_W'(rem_shift - {1'b0, relax_ticks_i}) : rem_q << 1;
      factor_q <= {factor_q[FB-2:0], qbit};
    end
    if (cmd_i.sub) begin
      neg_q <= diff[MAG_W-1];
      mag_q <= diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
    end
    if (cmd_i.mul_lo) begin
      acc_q <= ACC_W'(prod_lo);
    end else if (cmd_i.mul_hi) begin
      acc_q <= acc_q + (ACC_W'(prod_hi) << LO_W);
    end
    if (cmd_i.load_out) begin
      out_rel_q <= reloaded_q;
      for (int i = 0; i < NUM_COMP; i++) begin
        out_filt_q[i] <= filt_q[i];
      end
    end
  end

  assign filt_o     = out_filt_q;
  assign reloaded_o = out_rel_q;

endmodule

`default_nettype wire

// File: rtl/variable_step_relaxation_filter.sv
// Top level of the variable-step relaxation filter: ports, packing, configuration.
// Depends on vsrf_pkg, vsrf_ctrl and vsrf_datapath.
//
// Usage:
//   The slave stream carries one sample per transfer: a 32-bit timestamp and five
//   signed Q15.16 components. The master stream returns one filtered vector per
//   sample, with tuser set when the sample reloaded the state (relaxation disabled,
//   no value held or timestamp went back). The configuration channel writes
//   relax_enable (index 0) and relax_ticks (index 1); it is always ready, and the
//   user must write it only while the filter is idle: the block does not enforce it.
// Timing:
//   A sample that reloads the state, repeats the last timestamp or reaches the
//   full time constant is checked and its result is registered. A sample that is
//   filtered is checked, then runs the bit-serial divider for the blend factor, and
//   then the subtract, low-half, high-half and write steps for each component on
//   the shared split multiplier. The next sample is taken in the cycle after the
//   result is registered, so samples are handled one at a time.
//   A finished result waits in an output register; a stalled receiver blocks the
//   next result only, while the next sample is still taken and computed.
// Reset:
//   Clears the filter (no value held, last timestamp 0), disables relaxation and
//   sets relax_ticks to 1. The first sample after reset always reloads.
`default_nettype none

module variable_step_relaxation_filter import vsrf_pkg::*; #(
  parameter int MOMENT_WIDTH = 32,
  parameter int FACTOR_BITS  = 16,
  localparam int IN_BITS  = STAMP_W + NUM_COMP * MOMENT_WIDTH,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = NUM_COMP * MOMENT_WIDTH,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // sample stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_W-1:0]       s_axis_tdata,  // stamp, raw_0 .. raw_4, zero pad
  // filtered stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata,  // filt_0 .. filt_4, zero pad
  output logic                       m_axis_tuser   // reloaded
);

  localparam int MW = MOMENT_WIDTH;

  logic               relax_enable_q;
  logic [TICKS_W-1:0] relax_ticks_q;

  vsrf_cmd_t            cmd;
  vsrf_status_t         status;
  logic signed [MW-1:0] raw  [NUM_COMP];
  logic signed [MW-1:0] filt [NUM_COMP];
  logic [OUT_BITS-1:0]  filt_packed;

  // Configuration registers: always ready, one register per transfer.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_enable_q <= 1'b0;
      relax_ticks_q  <= TICKS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RELAX_ENABLE: relax_enable_q <= cfg_data_i[0];
        CFG_RELAX_TICKS:  relax_ticks_q  <= cfg_data_i[TICKS_W-1:0];
        default: begin
          relax_enable_q <= relax_enable_q;
        end
      endcase
    end
  end

  // Unpack the sample and pack the filtered vector, lowest field first.
  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      raw[i]                 = s_axis_tdata[STAMP_W + i*MW +: MW];
      filt_packed[i*MW +: MW] = filt[i];
    end
  end

  assign m_axis_tdata = OUT_W'(filt_packed);

  vsrf_ctrl #(
    .FACTOR_BITS (FACTOR_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vsrf_datapath #(
    .MOMENT_WIDTH (MOMENT_WIDTH),
    .FACTOR_BITS  (FACTOR_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .relax_enable_i (relax_enable_q),
    .relax_ticks_i  (relax_ticks_q),
    .stamp_i        (s_axis_tdata[STAMP_W-1:0]),
    .raw_i          (raw),
    .filt_o         (filt),
    .reloaded_o     (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: tb/sv/variable_step_relaxation_filter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for variable_step_relaxation_filter: a directed table of
// samples and register writes, then random phases under changing settings and stalls.
// Depends on vsrf_pkg and the filter RTL; needs no files or arguments.

module variable_step_relaxation_filter_test;
  import vsrf_pkg::*;

  localparam int MOMENT_W = 32;
  localparam int FACTOR_W = 16;
  localparam int VEC_W    = NUM_COMP * MOMENT_W;

  // Blend factor arithmetic, unsigned Q0.FACTOR_W carried in 64 bits.
  localparam logic [63:0] FACTOR_ONE  = 64'd1 << FACTOR_W;
  localparam logic [63:0] FACTOR_HALF = 64'd1 << (FACTOR_W - 1);
  localparam logic [63:0] FACTOR_FRAC = FACTOR_ONE - 64'd1;
  localparam longint      MOMENT_MAX  = (longint'(1) <<< (MOMENT_W - 1)) - 1;
  localparam longint      MOMENT_MIN  = -MOMENT_MAX - 1;

  typedef logic signed [MOMENT_W-1:0] moment_t;
  typedef logic [VEC_W-1:0] vec_t;  // component 0 in the lowest bits

  // Packed exactly as the slave tdata: stamp lowest, then raw_0 .. raw_4.
  typedef struct packed {
    vec_t               raw;
    logic [STAMP_W-1:0] stamp;
  } sample_t;

  // Packed as {tuser, tdata} of the master side.
  typedef struct packed {
    logic reloaded;
    vec_t filt;
  } filt_result_t;

  typedef enum logic {
    ROW_CFG,
    ROW_SAMPLE
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
    sample_t               smp;
    bit                    known;  // expected result typed into the table
    filt_result_t          want;
  } stim_row_t;

  // Directed vectors: field extremes, Q15.16 values and rounding ties.
  localparam vec_t VEC_EXT_A = {32'h00000001, 32'hFFFFFFFF, 32'h00000000,
                                32'h80000000, 32'h7FFFFFFF};
  localparam vec_t VEC_EXT_B = {32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF,
                                32'h7FFFFFFF, 32'h80000000};
  localparam vec_t VEC_X     = {32'h00010000, 32'hFFFF0000, 32'h12345678,
                                32'hEDCBA988, 32'h00000000};
  localparam vec_t VEC_Y     = {32'h00050000, 32'hFFFB0000, 32'h00000000,
                                32'h40000000, 32'hC0000000};
  localparam vec_t VEC_Z     = {32'h00000003, 32'hFFFFFFFD, 32'h7FFFFFFF,
                                32'h80000000, 32'h00008000};
  localparam vec_t VEC_TIE   = {32'h7FFFFFFF, 32'hFFFFFFFD, 32'h00000003,
                                32'hFFFFFFFF, 32'h00000001};
  localparam vec_t VEC_ZERO  = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index = CFG_RELAX_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic    s_valid = 1'b0;
  logic    s_axis_tready;
  sample_t s_data  = '0;

  logic             m_axis_tvalid;
  logic             m_ready = 1'b0;
  logic [VEC_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  // Idle percentages of the sender and the receiver for the current phase.
  int src_idle = 22;
  int snk_idle = 50;

  int mismatch_count = 0;

  // Filter state and register copies that the predictor keeps.
  vec_t               flt_state      = '0;
  logic [STAMP_W-1:0] flt_last_stamp = '0;
  logic               flt_have_value = 1'b0;
  logic               cfg_enable     = 1'b0;
  logic [TICKS_W-1:0] cfg_ticks      = TICKS_RESET;

  filt_result_t filtered_due[$];  // expected filtered vectors, oldest first
  stim_row_t    stim_rows[$];

  always #5 clk_i = ~clk_i;

  variable_step_relaxation_filter #(
    .MOMENT_WIDTH(MOMENT_W),
    .FACTOR_BITS (FACTOR_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),          // stamp, raw_0 .. raw_4
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),    // filt_0 .. filt_4
    .m_axis_tuser (m_axis_tuser)     // reloaded
  );

  // Advance the filter copy by one accepted sample and return its result.
  function automatic filt_result_t relax_predict(input sample_t smp);
    filt_result_t res;
    logic [63:0]  elapsed;
    logic [63:0]  factor;
    logic [63:0]  mag;
    logic [63:0]  step;
    longint       raw;
    longint       cur;
    longint       diff;
    longint       nxt;
    int           i;
    res.reloaded = 1'b0;
    if (!cfg_enable || !flt_have_value || smp.stamp < flt_last_stamp) begin
      // Disabled, empty or stamp went back: load the raw vector as it is.
      flt_state      = smp.raw;
      flt_last_stamp = smp.stamp;
      flt_have_value = 1'b1;
      res.reloaded   = 1'b1;
    end else if (smp.stamp != flt_last_stamp) begin
      elapsed = 64'(smp.stamp - flt_last_stamp);
      if (cfg_ticks == '0) begin
        factor = FACTOR_ONE;
      end else begin
        factor = (elapsed << FACTOR_W) / 64'(cfg_ticks);
      end
      if (factor > FACTOR_ONE) factor = FACTOR_ONE;
      for (i = 0; i < NUM_COMP; i++) begin
        raw = longint'($signed(smp.raw[i*MOMENT_W +: MOMENT_W]));
        cur = longint'($signed(flt_state[i*MOMENT_W +: MOMENT_W]));
        if (factor == FACTOR_ONE) begin
          nxt = raw;
        end else begin
          // Round the step magnitude half away from zero, split to stay in 64 bits.
          diff = raw - cur;
          mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
          step = (mag >> FACTOR_W) * factor
               + (((mag & FACTOR_FRAC) * factor + FACTOR_HALF) >> FACTOR_W);
          nxt  = (diff < 0) ? cur - longint'(step) : cur + longint'(step);
        end
        if (nxt > MOMENT_MAX) nxt = MOMENT_MAX;
        else if (nxt < MOMENT_MIN) nxt = MOMENT_MIN;
        flt_state[i*MOMENT_W +: MOMENT_W] = nxt[MOMENT_W-1:0];
      end
      flt_last_stamp = smp.stamp;
    end
    res.filt = flt_state;
    return res;
  endfunction

  function automatic void add_cfg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.data  = val;
    row.smp   = '0;
    row.known = 1'b0;
    row.want  = '0;
    stim_rows.push_back(row);
  endfunction

  // Sample row; a known row carries its expected vector and reload flag.
  function automatic void add_smp(input logic [STAMP_W-1:0] stamp, input vec_t raw,
                                  input bit known = 1'b0, input vec_t want = '0,
                                  input logic rl = 1'b0);
    stim_row_t row;
    row.kind      = ROW_SAMPLE;
    row.idx       = CFG_RELAX_ENABLE;
    row.data      = '0;
    row.smp.stamp = stamp;
    row.smp.raw   = raw;
    row.known     = known;
    row.want      = {rl, want};
    stim_rows.push_back(row);
  endfunction

  // Write one register at a falling edge, hold until the transfer, drop valid.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RELAX_ENABLE: cfg_enable = val[0];
      CFG_RELAX_TICKS:  cfg_ticks  = val;
      default:          ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one sample after a random gap; queue its expected result on transfer.
  task automatic send_sample(input sample_t smp, input bit known, input filt_result_t want);
    filt_result_t pred;
    while ($urandom_range(99) < src_idle) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = relax_predict(smp);
    filtered_due.push_back(known ? want : pred);
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every expected result, plus a short settle time.
  task automatic drain_results();
    s_valid <= 1'b0;
    while (filtered_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Receiver: stall at random at every falling edge.
  always @(negedge clk_i) begin
    m_ready <= ($urandom_range(99) >= snk_idle);
  end

  // Compare every output transfer with the oldest expected vector.
  always @(posedge clk_i) begin : check_results
    filt_result_t got;
    filt_result_t want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (filtered_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = filtered_due.pop_front();
        for (int i = 0; i < NUM_COMP; i++) begin
          if (got.filt[i*MOMENT_W +: MOMENT_W] !== want.filt[i*MOMENT_W +: MOMENT_W]) begin
            $display("%0t: filt_%0d expected %h actual %h", $time, i,
                     want.filt[i*MOMENT_W +: MOMENT_W], got.filt[i*MOMENT_W +: MOMENT_W]);
            mismatch_count++;
          end
        end
        if (got.reloaded !== want.reloaded) begin
          $display("%0t: reloaded expected %b actual %b", $time,
                   want.reloaded, got.reloaded);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    sample_t               smp;
    logic [STAMP_W-1:0]    stamp_now;
    logic [STAMP_W:0]      stamp_sum;
    logic [TICKS_W-1:0]    ticks;
    logic [TICKS_W-1:0]    span;
    vec_t                  raw_prev;
    moment_t               comp;
    int                    pick;

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table. Reset leaves relaxation off, so forward stamps still reload.
    add_smp(32'd100, VEC_EXT_A, 1'b1, VEC_EXT_A, 1'b1);
    add_smp(32'd200, VEC_EXT_B, 1'b1, VEC_EXT_B, 1'b1);
    add_cfg(CFG_RELAX_ENABLE, 32'd1);
    add_cfg(CFG_RELAX_TICKS, 32'd1000);
    add_smp(32'd10, VEC_X, 1'b1, VEC_X, 1'b1);           // stamp goes back
    add_smp(32'd10, VEC_Y, 1'b1, VEC_X, 1'b0);           // equal stamp holds
    add_smp(32'd1010, VEC_Y, 1'b1, VEC_Y, 1'b0);         // full time constant
    add_smp(32'd1510, VEC_Z);                            // half step
    add_smp(32'd1760, VEC_EXT_A);
    add_smp(32'd1761, VEC_EXT_B);
    add_smp(32'hFFFFFFFF, VEC_EXT_B, 1'b1, VEC_EXT_B, 1'b0);
    add_smp(32'd0, VEC_EXT_A, 1'b1, VEC_EXT_A, 1'b1);
    add_cfg(CFG_RELAX_TICKS, 32'hFFFFFFFF);
    add_smp(32'd1, VEC_EXT_B, 1'b1, VEC_EXT_A, 1'b0);    // factor truncates to zero
    add_smp(32'hFFFFFFFF, VEC_EXT_B);                    // factor just below one
    add_smp(32'd0, VEC_X, 1'b1, VEC_X, 1'b1);
    add_cfg(CFG_RELAX_TICKS, 32'd2);
    add_cfg(CFG_RELAX_ENABLE, 32'd0);
    add_smp(32'd7, VEC_ZERO, 1'b1, VEC_ZERO, 1'b1);
    add_cfg(CFG_RELAX_ENABLE, 32'd1);
    add_smp(32'd8, VEC_TIE);                             // rounding ties both signs
    add_smp(32'd10, VEC_TIE, 1'b1, VEC_TIE, 1'b0);

    // Walk the table; registers change only once the filter has gone idle.
    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_CFG) begin
        drain_results();
        write_reg(stim_rows[r].idx, stim_rows[r].data);
      end else begin
        send_sample(stim_rows[r].smp, stim_rows[r].known, stim_rows[r].want);
      end
    end

    // Random phases: sender idles less than the receiver, then the reverse,
    // then neither idles. Each segment picks new register settings.
    stamp_now = flt_last_stamp;
    raw_prev  = flt_state;
    for (int seg = 0; seg < 12; seg++) begin
      src_idle = (seg < 4) ? 22 : (seg < 8) ? 50 : 0;
      snk_idle = (seg < 4) ? 50 : (seg < 8) ? 22 : 0;
      case (seg % 4)
        0:       ticks = 32'd1;
        1:       ticks = 32'hFFFFFFFF;
        2:       ticks = $urandom_range(64, 2);
        default: begin
          ticks = $urandom;
          if (ticks == '0) ticks = 32'd1;
        end
      endcase
      drain_results();
      write_reg(CFG_RELAX_ENABLE, (seg % 6 == 5) ? 32'd0 : 32'd1);
      write_reg(CFG_RELAX_TICKS, ticks);

      for (int n = 0; n < 150; n++) begin
        // Mostly forward stamps at a spread of fractions of the time constant;
        // the rest repeat, go back or jump anywhere.
        pick = $urandom_range(99);
        if (pick < 8) begin
          smp.stamp = stamp_now;
        end else if (pick < 16) begin
          smp.stamp = $urandom_range(stamp_now, 0);
        end else if (pick < 20) begin
          smp.stamp = $urandom;
        end else begin
          if (pick < 28) span = ticks;
          else if (ticks <= 64) span = $urandom_range(2 * ticks, 1);
          else span = $urandom_range(ticks >> $urandom_range(10, 0), 1);
          stamp_sum = {1'b0, stamp_now} + span;
          // Restart near zero when the stamp would wrap.
          smp.stamp = stamp_sum[STAMP_W] ? STAMP_W'($urandom_range(1000, 0))
                                         : stamp_sum[STAMP_W-1:0];
        end

        // Components: full random, extremes, or a nearby walk from the last raw.
        for (int i = 0; i < NUM_COMP; i++) begin
          pick = $urandom_range(99);
          if (pick < 15) begin
            comp = $urandom;
          end else if (pick < 25) begin
            case ($urandom_range(3, 0))
              0:       comp = 32'h7FFFFFFF;
              1:       comp = 32'h80000000;
              2:       comp = 32'h00000000;
              default: comp = 32'hFFFFFFFF;
            endcase
          end else begin
            comp = moment_t'(raw_prev[i*MOMENT_W +: MOMENT_W])
                 + ((moment_t'($urandom_range(65535, 0)) - 32768) <<< $urandom_range(14, 0));
          end
          smp.raw[i*MOMENT_W +: MOMENT_W] = comp;
        end
        raw_prev  = smp.raw;
        stamp_now = smp.stamp;
        send_sample(smp, 1'b0, '0);
      end
    end

    drain_results();
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0 && filtered_due.size() == 0) begin
      $display("variable_step_relaxation_filter verification clean");
    end else begin
      $display("variable_step_relaxation_filter verification failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("variable_step_relaxation_filter verification failed");
    $finish;
  end

endmodule
